/* design/sbse_pkg.sv */
// Shared types and constants for the baseboard serial extractor.
package sbse_pkg;

    localparam int OFFSET_WIDTH_DEF = 32;
    localparam int QUEUE_DEPTH      = 4;
    localparam int CMP_W            = 34;   // room for 32-bit offsets plus small adds
    localparam int LEN_W            = 32;   // header length field
    localparam logic [7:0] TYPE_BASEBOARD = 8'h02;
    localparam logic [7:0] SERIAL_OFS     = 8'h07;
    localparam logic [7:0] MIN_BB_LEN     = 8'h08;
    localparam logic [7:0] MAX_CHARS      = 8'hFF;
    localparam logic [2:0] HDR_LAST       = 3'd7;
    localparam logic [CMP_W-1:0] MIN_TABLE = CMP_W'(5);

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NOBOARD   = 3'd1,
        ST_ZEROIDX   = 3'd2,
        ST_EMPTY     = 3'd3,
        ST_MALFORMED = 3'd4
    } status_t;

    // classified input word
    typedef struct packed {
        logic [7:0] data;
        logic       start;
        logic       is_zero;
        logic       is_type2;
    } item_t;

endpackage

/* design/sbse_front.sv */
// Input side: takes stream words, tags them and pushes them into the queue.
module sbse_front
    import sbse_pkg::*;
(
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] data_byte
    input  logic       s_tuser,   // [0] table_start
    input  logic       q_full,
    output logic       q_push,
    output item_t      q_item
);

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;

    always_comb
    begin
        q_item.data     = s_tdata;
        q_item.start    = s_tuser;
        q_item.is_zero  = (s_tdata == 8'h00);
        q_item.is_type2 = (s_tdata == TYPE_BASEBOARD);
    end

endmodule

/* design/sbse_queue.sv */
// Short flop-based queue between the front and the walker.
module sbse_queue
    import sbse_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  item_t push_item,
    input  logic  pop,
    output item_t head,
    output logic  full,
    output logic  empty
);

    localparam int PW = $clog2(QUEUE_DEPTH);

    item_t           mem_reg [QUEUE_DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [PW:0]     count_reg, count_next;

    assign full  = (count_reg == (PW+1)'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + PW'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + PW'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + (PW+1)'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - (PW+1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

/* design/sbse_walker.sv */
// Structure walker: tracks header, structures and strings, drives the result register.
module sbse_walker
    import sbse_pkg::*;
#(
    parameter int OFFSET_WIDTH = OFFSET_WIDTH_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  item_t      head,
    input  logic       q_empty,
    output logic       q_pop,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] out_char,
    output logic       out_char_valid,
    output logic       out_done,
    output status_t    out_status,
    output logic [7:0] out_length
);

    localparam int W = OFFSET_WIDTH;

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_STRUCT,
        PH_SKIP,
        PH_COPY
    } phase_t;

    phase_t             phase_reg, phase_next;
    logic [W-1:0]       ofs_reg, ofs_next;
    logic [LEN_W-1:0]   tlen_reg, tlen_next;
    logic [W-1:0]       sstart_reg, sstart_next;
    logic [7:0]         slen_reg, slen_next;
    logic [7:0]         stype_reg, stype_next;
    logic               prev_zero_reg, prev_zero_next;
    logic [7:0]         skip_reg, skip_next;
    logic [7:0]         nchars_reg, nchars_next;
    logic               fin_reg, fin_next;

    logic               valid_reg;
    logic [7:0]         char_reg;
    logic               cvalid_reg;
    logic               done_reg;
    status_t            status_reg;
    logic [7:0]         length_reg;

    logic               emit;
    logic [7:0]         e_char;
    logic               e_cvalid;
    status_t            e_status;
    logic               e_done;

    assign q_pop          = !q_empty && (!valid_reg || m_tready);
    assign m_tvalid       = valid_reg;
    assign out_char       = char_reg;
    assign out_char_valid = cvalid_reg;
    assign out_done       = done_reg;
    assign out_status     = status_reg;
    assign out_length     = length_reg;

    always_comb
    begin
        logic [W-1:0]     b;
        logic [W-1:0]     b_sat;
        logic [W-1:0]     j;
        logic [7:0]       l;
        logic [CMP_W-1:0] bx, sx, tx, lx, jx, nsx;
        logic [7:0]       skip_dec;

        phase_next     = phase_reg;
        ofs_next       = ofs_reg;
        tlen_next      = tlen_reg;
        sstart_next    = sstart_reg;
        slen_next      = slen_reg;
        stype_next     = stype_reg;
        prev_zero_next = prev_zero_reg;
        skip_next      = skip_reg;
        nchars_next    = nchars_reg;
        fin_next       = fin_reg;
        emit           = 1'b0;
        e_char         = 8'h00;
        e_cvalid       = 1'b0;
        e_status       = ST_OK;
        e_done         = 1'b0;

        if (head.start)
        begin
            phase_next     = PH_HEADER;
            ofs_next       = '0;
            tlen_next      = '0;
            sstart_next    = '0;
            slen_next      = '0;
            stype_next     = '0;
            prev_zero_next = 1'b0;
            skip_next      = '0;
            nchars_next    = '0;
            fin_next       = 1'b0;
        end

        b        = ofs_next;
        b_sat    = (b == {W{1'b1}}) ? b : b + W'(1);
        j        = b - sstart_next;
        l        = slen_next;
        lx       = CMP_W'(l);
        bx       = CMP_W'(b);
        sx       = CMP_W'(sstart_next);
        tx       = CMP_W'(tlen_next);
        jx       = CMP_W'(j);
        nsx      = CMP_W'(b_sat);
        skip_dec = skip_next;

        if (!fin_next)
        begin
            unique case (phase_next)
                PH_HEADER:
                begin
                    if (b[2])
                    begin
                        tlen_next[8*b[1:0] +: 8] = head.data;
                    end
                    if (b[2:0] == HDR_LAST)
                    begin
                        ofs_next       = '0;
                        phase_next     = PH_STRUCT;
                        sstart_next    = '0;
                        prev_zero_next = 1'b0;
                        if (CMP_W'(tlen_next) < MIN_TABLE)
                        begin
                            emit     = 1'b1;
                            e_done   = 1'b1;
                            e_status = ST_NOBOARD;
                        end
                    end
                    else
                    begin
                        ofs_next = b + W'(1);
                    end
                end
                PH_STRUCT:
                begin
                    ofs_next       = b_sat;
                    prev_zero_next = head.is_zero;
                    if (j == '0)
                    begin
                        stype_next = head.data;
                        if (head.is_type2 && !(sx + CMP_W'(SERIAL_OFS) < tx))
                        begin
                            emit     = 1'b1;
                            e_done   = 1'b1;
                            e_status = ST_NOBOARD;
                        end
                    end
                    else
                    begin
                        if (j == W'(1))
                        begin
                            slen_next = head.data;
                            l         = head.data;
                        end
                        lx = CMP_W'(l);
                        if (stype_next == TYPE_BASEBOARD)
                        begin
                            if (j == W'(1) && l < MIN_BB_LEN)
                            begin
                                emit     = 1'b1;
                                e_done   = 1'b1;
                                e_status = ST_MALFORMED;
                            end
                            else if (jx == CMP_W'(SERIAL_OFS))
                            begin
                                if (head.is_zero)
                                begin
                                    emit     = 1'b1;
                                    e_done   = 1'b1;
                                    e_status = ST_ZEROIDX;
                                end
                                else if (sx + lx >= tx)
                                begin
                                    emit     = 1'b1;
                                    e_done   = 1'b1;
                                    e_status = ST_EMPTY;
                                end
                                else
                                begin
                                    skip_next  = head.data - 8'd1;
                                    phase_next = (skip_next != '0) ? PH_SKIP : PH_COPY;
                                end
                            end
                        end
                        else if (j == W'(1) && sx + lx + CMP_W'(1) >= tx)
                        begin
                            emit     = 1'b1;
                            e_done   = 1'b1;
                            e_status = ST_NOBOARD;
                        end
                        else if (jx >= lx + CMP_W'(1) && prev_zero_reg && head.is_zero)
                        begin
                            // double null closes the string set: next structure
                            sstart_next    = b_sat;
                            prev_zero_next = 1'b0;
                            if (nsx + CMP_W'(4) >= tx)
                            begin
                                emit     = 1'b1;
                                e_done   = 1'b1;
                                e_status = ST_NOBOARD;
                            end
                        end
                        else if (bx + CMP_W'(1) >= tx)
                        begin
                            emit     = 1'b1;
                            e_done   = 1'b1;
                            e_status = ST_NOBOARD;
                        end
                    end
                end
                PH_SKIP:
                begin
                    ofs_next = b_sat;
                    if (!(bx < sx + CMP_W'(l)))
                    begin
                        if (head.is_zero && skip_dec != '0)
                        begin
                            skip_dec = skip_dec - 8'd1;
                        end
                        skip_next = skip_dec;
                        if (bx + CMP_W'(1) >= tx)
                        begin
                            emit     = 1'b1;
                            e_done   = 1'b1;
                            e_status = ST_EMPTY;
                        end
                        else if (skip_dec == '0)
                        begin
                            phase_next = PH_COPY;
                        end
                    end
                end
                PH_COPY:
                begin
                    ofs_next = b_sat;
                    if (!(bx < sx + CMP_W'(l)))
                    begin
                        emit = 1'b1;
                        if (head.is_zero)
                        begin
                            e_done   = 1'b1;
                            e_status = (nchars_next != '0) ? ST_OK : ST_EMPTY;
                        end
                        else
                        begin
                            nchars_next = nchars_next + 8'd1;
                            e_char      = head.data;
                            e_cvalid    = 1'b1;
                            if (nchars_next >= MAX_CHARS || bx + CMP_W'(1) >= tx)
                            begin
                                e_done = 1'b1;
                            end
                        end
                    end
                end
                default:
                begin
                    phase_next = PH_HEADER;
                end
            endcase
            if (e_done)
            begin
                fin_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HEADER;
            ofs_reg       <= '0;
            tlen_reg      <= '0;
            sstart_reg    <= '0;
            slen_reg      <= '0;
            stype_reg     <= '0;
            prev_zero_reg <= 1'b0;
            skip_reg      <= '0;
            nchars_reg    <= '0;
            fin_reg       <= 1'b1;
            valid_reg     <= 1'b0;
            char_reg      <= '0;
            cvalid_reg    <= 1'b0;
            done_reg      <= 1'b0;
            status_reg    <= ST_OK;
            length_reg    <= '0;
        end
        else
        begin
            if (q_pop)
            begin
                phase_reg     <= phase_next;
                ofs_reg       <= ofs_next;
                tlen_reg      <= tlen_next;
                sstart_reg    <= sstart_next;
                slen_reg      <= slen_next;
                stype_reg     <= stype_next;
                prev_zero_reg <= prev_zero_next;
                skip_reg      <= skip_next;
                nchars_reg    <= nchars_next;
                fin_reg       <= fin_next;
            end
            if (q_pop && emit)
            begin
                valid_reg  <= 1'b1;
                char_reg   <= e_char;
                cvalid_reg <= e_cvalid;
                done_reg   <= e_done;
                status_reg <= e_status;
                length_reg <= nchars_next;
            end
            else if (m_tready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

endmodule

/* design/smbios_baseboard_serial_extract_top.sv */
// Top level of the SMBIOS baseboard serial extractor.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+----------------------------------------------
//  s_*     | in  | s_tvalid/s_tready  | tdata: data_byte; tuser: table_start
//  m_*     | out | m_tvalid/m_tready  | tdata: serial_char, serial_length;
//          |     |                    | tuser: char_valid, status; tlast: done_res
//
// One word per cycle sustained while m_tready keeps up; the walker decides each byte combinationally.
// An accepted word is queued, then popped when the walker can take it; its result is registered onto m_*.
// rst_n is asynchronous; after reset the block ignores words until one carries table_start.
// A four-word queue lets input keep flowing while a result waits for m_tready.
module smbios_baseboard_serial_extract_top
    import sbse_pkg::*;
#(
    parameter int OFFSET_WIDTH = OFFSET_WIDTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // [0] table_start
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] serial_char, [15:8] serial_length
    output logic [3:0]  m_tuser,   // [0] char_valid, [3:1] status
    output logic        m_tlast    // done_res
);

    logic       q_full;
    logic       q_empty;
    logic       q_push;
    logic       q_pop;
    item_t      q_in_item;
    item_t      q_head;
    logic [7:0] out_char;
    logic       out_char_valid;
    logic       out_done;
    status_t    out_status;
    logic [7:0] out_length;

    sbse_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_item   (q_in_item)
    );

    sbse_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (q_in_item),
        .pop       (q_pop),
        .head      (q_head),
        .full      (q_full),
        .empty     (q_empty)
    );

    sbse_walker #(
        .OFFSET_WIDTH (OFFSET_WIDTH)
    ) u_walker (
        .clk            (clk),
        .rst_n          (rst_n),
        .head           (q_head),
        .q_empty        (q_empty),
        .q_pop          (q_pop),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .out_char       (out_char),
        .out_char_valid (out_char_valid),
        .out_done       (out_done),
        .out_status     (out_status),
        .out_length     (out_length)
    );

    assign m_tdata = {out_length, out_char};
    assign m_tuser = {out_status, out_char_valid};
    assign m_tlast = out_done;

endmodule
